### rtl/core/sha256_pkg.sv
`timescale 1ns / 1ps
package sha256_pkg;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
        rotr = (x >> n) | (x << (6'd32 - {1'b0, n}));
    endfunction

endpackage

### rtl/core/sha256_compress.sv
`timescale 1ns / 1ps
module sha256_compress (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    output logic [3:0]  o_word_addr,
    input  logic [31:0] i_word_data,
    input  logic        i_hash_clear,
    input  logic [2:0]  i_hash_addr,
    output logic [31:0] o_hash_data
);

    typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_ROUND, ST_ADD} t_state;

    t_state      r_state;
    logic [6:0]  r_cnt;
    logic [31:0] r_hash [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];

    logic [5:0]  rnd;
    logic [31:0] wr, s0, s1, t1, t2, e, a, x, y;

    // block memory word r_cnt arrives in the cycle after its address
    assign o_word_addr = r_cnt[3:0];
    assign o_busy = (r_state != ST_IDLE);
    assign o_hash_data = r_hash[i_hash_addr];

    always_comb begin
        rnd = r_cnt[5:0];
        x = r_w[1];
        y = r_w[14];
        s0 = sha256_pkg::rotr(x, 5'd7) ^ sha256_pkg::rotr(x, 5'd18) ^ (x >> 3);
        s1 = sha256_pkg::rotr(y, 5'd17) ^ sha256_pkg::rotr(y, 5'd19) ^ (y >> 10);
        wr = (rnd < 6'd16) ? r_w[0] : (r_w[0] + s0 + r_w[9] + s1);
        e = r_v[4];
        a = r_v[0];
        t1 = r_v[7] + (sha256_pkg::rotr(e, 5'd6) ^ sha256_pkg::rotr(e, 5'd11)
            ^ sha256_pkg::rotr(e, 5'd25)) + ((e & r_v[5]) ^ (~e & r_v[6]))
            + sha256_pkg::ROUND_K[rnd] + wr;
        t2 = (sha256_pkg::rotr(a, 5'd2) ^ sha256_pkg::rotr(a, 5'd13)
            ^ sha256_pkg::rotr(a, 5'd22)) + ((a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt <= '0;
            for (int i = 0; i < 8; i++) r_hash[i] <= sha256_pkg::INIT_HASH[i];
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    r_cnt <= '0;
                    if (i_hash_clear) begin
                        for (int i = 0; i < 8; i++) r_hash[i] <= sha256_pkg::INIT_HASH[i];
                    end
                    if (i_start) r_state <= ST_LOAD;
                end
                ST_LOAD: begin
                    // shift-line of w: w[0] is the current round word
                    if (r_cnt != 7'd0) begin
                        r_w[15] <= i_word_data;
                        for (int i = 0; i < 15; i++) r_w[i] <= r_w[i + 1];
                    end
                    if (r_cnt == 7'd16) begin
                        r_cnt <= '0;
                        r_state <= ST_ROUND;
                        for (int i = 0; i < 8; i++) r_v[i] <= r_hash[i];
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                ST_ROUND: begin
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i + 1];
                    r_w[15] <= wr;
                    r_v[7] <= r_v[6];
                    r_v[6] <= r_v[5];
                    r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2];
                    r_v[2] <= r_v[1];
                    r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                    if (r_cnt == 7'd63) r_state <= ST_ADD;
                    r_cnt <= r_cnt + 7'd1;
                end
                ST_ADD: begin
                    for (int i = 0; i < 8; i++) r_hash[i] <= r_hash[i] + r_v[i];
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_hash_clear |-> !o_busy) else $error("hash clear while busy");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("start not taken");
    a_round_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ADD) |-> (r_cnt == 7'd64)) else $error("round count");

endmodule

### rtl/core/sha256_byte_stream_hasher.sv
`timescale 1ns / 1ps
// sha-256 over a byte stream
// input channel (i_in_valid, o_in_stall, i_in_data): command append carries one
// message byte, command finish pads the message and starts the digest output
// output channel (o_out_valid, i_out_stall, o_out_data): eight digest words,
// h0 first, last_word set on word seven
// an append writes one byte into the 64-byte block memory without a stall; the
// 64th byte starts a compression during which input is stalled (start, word
// reads from the block memory, 64 rounds, final add, return to idle)
// a finish writes the padding one byte a cycle into the block memory, runs one
// or two compressions, then presents eight words, one per cycle while the
// receiver does not stall; a stalled word holds until taken and the next
// message is taken once all eight words are transferred
// reset returns the hash to the initial values and empties the block; the
// block memory contents are not cleared
module sha256_byte_stream_hasher (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  sha256_pkg::t_in_item  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output sha256_pkg::t_out_item o_out_data
);

    typedef enum logic [2:0] {ST_IDLE, ST_WAIT, ST_PAD, ST_PWAIT, ST_OUT} t_state;

    t_state      r_state;
    logic [5:0]  r_fill;
    logic [63:0] r_count;
    logic [63:0] r_bits;
    logic [2:0]  r_widx;
    logic        r_start;
    logic        r_clear;
    logic        r_len_blk;
    logic [31:0] r_mem [16];
    logic [31:0] r_rdata;

    logic        wr_en;
    logic [7:0]  wr_byte;
    logic [7:0]  pad_byte;
    logic [3:0]  word_addr;
    logic        cbusy;
    logic [31:0] hash_data;
    logic        in_xfer;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_xfer = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_state == ST_OUT);
    assign o_out_data.digest_word = hash_data;
    assign o_out_data.word_index = r_widx;
    assign o_out_data.last_word = (r_widx == 3'd7);

    // length bytes only in the block that carries the length
    always_comb begin
        pad_byte = 8'h00;
        if (r_len_blk && r_fill >= sha256_pkg::LEN_OFFSET) begin
            pad_byte = r_bits[{~r_fill[2:0], 3'b111} -: 8];
        end
    end

    always_comb begin
        wr_en = 1'b0;
        wr_byte = pad_byte;
        if (in_xfer) begin
            wr_en = 1'b1;
            wr_byte = (i_in_data.command == sha256_pkg::CMD_FINISH) ?
                sha256_pkg::PAD_BYTE : i_in_data.data_byte;
        end else if (r_state == ST_PAD) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <= wr_byte;
    end

    // big-endian word read, registered
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[word_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill <= '0;
            r_count <= '0;
            r_widx <= '0;
            r_start <= 1'b0;
            r_clear <= 1'b0;
            r_len_blk <= 1'b0;
        end else begin
            r_start <= 1'b0;
            r_clear <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        r_fill <= r_fill + 6'd1;
                        if (i_in_data.command == sha256_pkg::CMD_FINISH) begin
                            r_bits <= {r_count[60:0], 3'b000};
                            r_len_blk <= (r_fill < sha256_pkg::LEN_OFFSET);
                            if (r_fill == 6'd63) begin
                                r_start <= 1'b1;
                                r_state <= ST_PWAIT;
                            end else begin
                                r_state <= ST_PAD;
                            end
                        end else begin
                            r_count <= r_count + 64'd1;
                            if (r_fill == 6'd63) begin
                                r_start <= 1'b1;
                                r_state <= ST_WAIT;
                            end
                        end
                    end
                end
                ST_WAIT: begin
                    if (!r_start && !cbusy) r_state <= ST_IDLE;
                end
                ST_PAD: begin
                    r_fill <= r_fill + 6'd1;
                    if (r_fill == 6'd63) begin
                        r_start <= 1'b1;
                        r_state <= ST_PWAIT;
                    end
                end
                ST_PWAIT: begin
                    if (!r_start && !cbusy) begin
                        // length block compressed means done
                        r_widx <= '0;
                        if (r_len_blk) begin
                            r_state <= ST_OUT;
                        end else begin
                            r_len_blk <= 1'b1;
                            r_state <= ST_PAD;
                        end
                    end
                end
                ST_OUT: begin
                    if (!i_out_stall) begin
                        r_widx <= r_widx + 3'd1;
                        if (r_widx == 3'd7) begin
                            r_clear <= 1'b1;
                            r_count <= '0;
                            r_state <= ST_WAIT;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    sha256_compress u_comp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (r_start),
        .o_busy       (cbusy),
        .o_word_addr  (word_addr),
        .i_word_data  (r_rdata),
        .i_hash_clear (r_clear),
        .i_hash_addr  (r_widx),
        .o_hash_data  (hash_data)
    );

    a_no_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall) else $error("input open during output");
    a_pad_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |-> (r_fill == 6'd0)) else $error("block not empty");
    a_start_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |=> !r_start) else $error("start held");

endmodule
